>>> rtl/aen_pkg.sv
// Package for the Accept-Encoding negotiator: types, codes and the token table.
// No dependencies; used by every file in rtl/.
package aen_pkg;

    localparam int QUEUE_DEPTH = 4;
    localparam int NAME_COUNT  = 6;
    localparam int WILD_IDX    = 5;
    localparam int IDENT_IDX   = 4;

    typedef enum logic [2:0] {
        PH_TOK_LEAD = 3'd0,
        PH_TOK_BODY = 3'd1,
        PH_PAR_LEAD = 3'd2,
        PH_PAR_Q    = 3'd3,
        PH_PAR_VAL  = 3'd4,
        PH_PAR_SKIP = 3'd5
    } phase_t;

    typedef enum logic [3:0] {
        QS_IDLE  = 4'd0,
        QS_ZERO  = 4'd1,
        QS_ONE   = 4'd2,
        QS_ZPT   = 4'd3,
        QS_ZD1   = 4'd4,
        QS_ZD2   = 4'd5,
        QS_ZD3   = 4'd6,
        QS_OPT   = 4'd7,
        QS_OD1   = 4'd8,
        QS_OD2   = 4'd9,
        QS_OD3   = 4'd10,
        QS_BAD   = 4'd15
    } qstate_t;

    typedef enum logic [1:0] {
        ST_CODING   = 2'd0,
        ST_PLAIN    = 2'd1,
        ST_MALFORM  = 2'd2,
        ST_NOACCEPT = 2'd3
    } status_t;

    localparam logic [9:0] FULL_WEIGHT = 10'd1000;

    // one element summary, front to back
    typedef struct packed {
        logic                  commit;
        logic [NAME_COUNT-1:0] flags;
        logic [9:0]            weight;
        logic                  malformed;
        logic                  nonblank;
        logic                  last;
    } elem_t;

    function automatic logic [3:0] name_len(input logic [2:0] idx);
        case (idx)
            3'd0, 3'd1: name_len = 4'd4;
            3'd2, 3'd3: name_len = 4'd3;
            3'd4:       name_len = 4'd8;
            default:    name_len = 4'd1;
        endcase
    endfunction

    function automatic logic [7:0] name_char(input logic [2:0] idx, input logic [2:0] pos);
        logic [63:0] txt;
        case (idx)
            3'd0:    txt = {32'd0, "dtsz"};
            3'd1:    txt = {32'd0, "pizg"};
            3'd2:    txt = {40'd0, "cxz"};
            3'd3:    txt = {40'd0, "4zl"};
            3'd4:    txt = "ytitnedi";
            default: txt = {56'd0, "*"};
        endcase
        name_char = txt[pos*8 +: 8];
    endfunction

endpackage

>>> rtl/accept_encoding_negotiator.sv
// Top level of the Accept-Encoding negotiator: front parser, queue, back decision.
// Depends on aen_pkg, aen_front, aen_queue, aen_back.
//
//  channel  | dir | tdata                                  | side bits
//  s_       | in  | header_byte[7:0]                       | tuser=has_byte, tlast=last
//  m_       | out | status[1:0] coding[3:2] weight[13:4]   | none
//
// One byte a cycle while s_tready is high; the front parser is the only per-byte
// loop. A result passes through the queue and then the output register. aresetn
// clears parser state, queue pointers and table seen flags. s_tready falls only when
// the queue is full; the back keeps folding non-last elements while a result waits on m_tready.
module accept_encoding_negotiator #(
    parameter int QUEUE_DEPTH = aen_pkg::QUEUE_DEPTH
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // header_byte[7:0]
    input  logic        s_tuser,   // has_byte
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata    // status[1:0], coding[3:2], weight[13:4], zero
);

    logic           push, pop, full, empty;
    aen_pkg::elem_t push_elem, head;

    assign s_tready = !full;

    aen_front u_front (
        .aclk, .aresetn,
        .in_fire (s_tvalid && s_tready),
        .in_byte (s_tdata),
        .in_has  (s_tuser),
        .in_last (s_tlast),
        .push, .push_elem
    );

    aen_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
        .aclk, .aresetn, .push, .push_elem, .full, .pop, .empty, .head
    );

    aen_back u_back (
        .aclk, .aresetn, .empty, .head, .pop,
        .m_valid (m_tvalid),
        .m_ready (m_tready),
        .m_data  (m_tdata)
    );

endmodule

>>> rtl/aen_front.sv
// Front end: parses one header byte a cycle, when a transfer fires, into element summaries.
// Depends on aen_pkg.
module aen_front (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           in_fire,
    input  logic [7:0]     in_byte,
    input  logic           in_has,
    input  logic           in_last,
    output logic           push,
    output aen_pkg::elem_t push_elem
);

    aen_pkg::phase_t  phase_reg, phase_next;
    aen_pkg::qstate_t qs_reg, qs_next;
    logic [5:0] flags_reg, flags_next;
    logic [3:0] pos_reg, pos_next;
    logic       pend_reg, pend_next;
    logic [9:0] ew_reg, ew_next;
    logic       enb_reg, enb_next;
    logic       fnb_reg, fnb_next;
    logic       mal_reg, mal_next;

    always_comb begin
        logic       ws, dig, comma, end_el;
        logic [7:0] c, lc;
        logic [9:0] d;
        c = in_byte;
        lc = (c >= "A" && c <= "Z") ? c + 8'd32 : c;
        ws = (c == 8'h20) || (c >= 8'h09 && c <= 8'h0D);
        dig = (c >= "0" && c <= "9");
        d = dig ? {2'b0, c - 8'h30} : 10'd0;
        phase_next = phase_reg; qs_next = qs_reg; flags_next = flags_reg;
        pos_next = pos_reg; pend_next = pend_reg; ew_next = ew_reg;
        enb_next = enb_reg; fnb_next = fnb_reg; mal_next = mal_reg;
        comma = 1'b0;
        push = 1'b0;
        push_elem = '0;
        if (in_fire && in_has) begin
            if (!ws) fnb_next = 1'b1;
            if (c == ",") begin
                comma = 1'b1;
            end else begin
                if (!ws) enb_next = 1'b1;
                if (c == ";") begin
                    // close token or weight part
                    if (phase_reg == aen_pkg::PH_TOK_LEAD || phase_reg == aen_pkg::PH_TOK_BODY) begin
                        for (int i = 0; i < aen_pkg::NAME_COUNT; i++)
                            if (pos_reg != aen_pkg::name_len(3'(i))) flags_next[i] = 1'b0;
                    end else if (phase_reg == aen_pkg::PH_PAR_VAL) begin
                        if (qs_reg == aen_pkg::QS_IDLE || qs_reg > aen_pkg::QS_OD3) mal_next = 1'b1;
                    end
                    pend_next = 1'b0;
                    phase_next = aen_pkg::PH_PAR_LEAD;
                end else begin
                    case (phase_reg)
                        aen_pkg::PH_TOK_LEAD, aen_pkg::PH_TOK_BODY: begin
                            if (ws) begin
                                if (phase_reg == aen_pkg::PH_TOK_BODY) pend_next = 1'b1;
                            end else begin
                                phase_next = aen_pkg::PH_TOK_BODY;
                                if (pend_reg) flags_next = '0;
                                for (int i = 0; i < aen_pkg::NAME_COUNT; i++)
                                    if (pos_reg >= aen_pkg::name_len(3'(i)) ||
                                        aen_pkg::name_char(3'(i), pos_reg[2:0]) != lc)
                                        flags_next[i] = 1'b0;
                                if (pos_reg != 4'd15) pos_next = pos_reg + 4'd1;
                            end
                        end
                        aen_pkg::PH_PAR_LEAD: begin
                            if (!ws) phase_next = (c == "q" || c == "Q") ?
                                aen_pkg::PH_PAR_Q : aen_pkg::PH_PAR_SKIP;
                        end
                        aen_pkg::PH_PAR_Q: begin
                            if (c == "=") begin
                                phase_next = aen_pkg::PH_PAR_VAL;
                                qs_next = aen_pkg::QS_IDLE;
                                ew_next = '0;
                                pend_next = 1'b0;
                            end else begin
                                phase_next = aen_pkg::PH_PAR_SKIP;
                            end
                        end
                        aen_pkg::PH_PAR_VAL: begin
                            if (ws) pend_next = 1'b1;
                            else if (pend_reg) qs_next = aen_pkg::QS_BAD;
                            else begin
                                case (qs_reg)
                                    aen_pkg::QS_IDLE:
                                        if (c == "0") begin
                                            qs_next = aen_pkg::QS_ZERO; ew_next = '0;
                                        end else if (c == "1") begin
                                            qs_next = aen_pkg::QS_ONE;
                                            ew_next = aen_pkg::FULL_WEIGHT;
                                        end else qs_next = aen_pkg::QS_BAD;
                                    aen_pkg::QS_ZERO:
                                        qs_next = (c == ".") ? aen_pkg::QS_ZPT : aen_pkg::QS_BAD;
                                    aen_pkg::QS_ONE:
                                        qs_next = (c == ".") ? aen_pkg::QS_OPT : aen_pkg::QS_BAD;
                                    aen_pkg::QS_ZPT:
                                        if (dig) begin
                                            qs_next = aen_pkg::QS_ZD1;
                                            ew_next = ew_reg + 10'(d * 10'd100);
                                        end else qs_next = aen_pkg::QS_BAD;
                                    aen_pkg::QS_ZD1:
                                        if (dig) begin
                                            qs_next = aen_pkg::QS_ZD2;
                                            ew_next = ew_reg + 10'(d * 10'd10);
                                        end else qs_next = aen_pkg::QS_BAD;
                                    aen_pkg::QS_ZD2:
                                        if (dig) begin
                                            qs_next = aen_pkg::QS_ZD3;
                                            ew_next = ew_reg + d;
                                        end else qs_next = aen_pkg::QS_BAD;
                                    aen_pkg::QS_OPT:
                                        qs_next = (c == "0") ? aen_pkg::QS_OD1 : aen_pkg::QS_BAD;
                                    aen_pkg::QS_OD1:
                                        qs_next = (c == "0") ? aen_pkg::QS_OD2 : aen_pkg::QS_BAD;
                                    aen_pkg::QS_OD2:
                                        qs_next = (c == "0") ? aen_pkg::QS_OD3 : aen_pkg::QS_BAD;
                                    default: qs_next = aen_pkg::QS_BAD;
                                endcase
                            end
                        end
                        default: ;
                    endcase
                end
            end
        end
        end_el = in_fire && (comma || in_last);
        if (end_el) begin
            // closing part of the element
            if (phase_next == aen_pkg::PH_TOK_LEAD || phase_next == aen_pkg::PH_TOK_BODY) begin
                for (int i = 0; i < aen_pkg::NAME_COUNT; i++)
                    if (pos_next != aen_pkg::name_len(3'(i))) flags_next[i] = 1'b0;
            end else if (phase_next == aen_pkg::PH_PAR_VAL) begin
                if (qs_next == aen_pkg::QS_IDLE || qs_next > aen_pkg::QS_OD3) mal_next = 1'b1;
            end
            push = 1'b1;
            push_elem.commit = enb_next;
            push_elem.flags = flags_next;
            push_elem.weight = ew_next;
            push_elem.malformed = mal_next;
            push_elem.nonblank = fnb_next;
            push_elem.last = in_last;
            phase_next = aen_pkg::PH_TOK_LEAD; qs_next = aen_pkg::QS_IDLE;
            flags_next = '1; pos_next = '0; pend_next = 1'b0;
            ew_next = aen_pkg::FULL_WEIGHT; enb_next = 1'b0;
            if (in_last) begin
                fnb_next = 1'b0; mal_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= aen_pkg::PH_TOK_LEAD; qs_reg <= aen_pkg::QS_IDLE;
            flags_reg <= '1; pos_reg <= '0; pend_reg <= 1'b0;
            ew_reg <= aen_pkg::FULL_WEIGHT; enb_reg <= 1'b0;
            fnb_reg <= 1'b0; mal_reg <= 1'b0;
        end else begin
            phase_reg <= phase_next; qs_reg <= qs_next; flags_reg <= flags_next;
            pos_reg <= pos_next; pend_reg <= pend_next; ew_reg <= ew_next;
            enb_reg <= enb_next; fnb_reg <= fnb_next; mal_reg <= mal_next;
        end
    end

endmodule

>>> rtl/aen_queue.sv
// Short FIFO of element summaries between front and back.
// Depends on aen_pkg.
module aen_queue #(
    parameter int DEPTH = aen_pkg::QUEUE_DEPTH
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           push,
    input  aen_pkg::elem_t push_elem,
    output logic           full,
    input  logic           pop,
    output logic           empty,
    output aen_pkg::elem_t head
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    aen_pkg::elem_t mem [DEPTH];
    logic [AW-1:0]  wr_reg, rd_reg;
    logic [AW:0]    cnt_reg;

    assign full  = (cnt_reg == (AW+1)'(DEPTH));
    assign empty = (cnt_reg == '0);
    assign head  = mem[rd_reg];

    always_ff @(posedge aclk) begin
        if (push) mem[wr_reg] <= push_elem;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_reg <= '0; rd_reg <= '0; cnt_reg <= '0;
        end else begin
            if (push) wr_reg <= (wr_reg == AW'(DEPTH-1)) ? '0 : wr_reg + AW'(1);
            if (pop)  rd_reg <= (rd_reg == AW'(DEPTH-1)) ? '0 : rd_reg + AW'(1);
            cnt_reg <= cnt_reg + (AW+1)'(push) - (AW+1)'(pop);
        end
    end

endmodule

>>> rtl/aen_back.sv
// Back end: folds element summaries into the weight table and decides.
// Depends on aen_pkg.
module aen_back (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           empty,
    input  aen_pkg::elem_t head,
    output logic           pop,
    output logic           m_valid,
    input  logic           m_ready,
    output logic [15:0]    m_data
);

    logic [4:0] seen_reg;
    logic [9:0] w_reg [5];
    logic       ws_reg;
    logic [9:0] ww_reg;
    logic       mv_reg;
    logic [15:0] md_reg;

    logic [4:0] seen_n;
    logic [9:0] w_n [5];
    logic       ws_n;
    logic [9:0] ww_n;
    logic [9:0] best, q, idw;
    logic [1:0] coding;
    aen_pkg::status_t status;

    assign m_valid = mv_reg;
    assign m_data  = md_reg;
    assign pop = !empty && (!head.last || !mv_reg || m_ready);

    always_comb begin
        seen_n = seen_reg; ws_n = ws_reg; ww_n = ww_reg;
        for (int i = 0; i < 5; i++) w_n[i] = w_reg[i];
        if (head.commit && !head.malformed) begin
            for (int i = 0; i < 5; i++)
                if (head.flags[i] && !seen_reg[i]) begin
                    seen_n[i] = 1'b1; w_n[i] = head.weight;
                end
            if (head.flags[aen_pkg::WILD_IDX]) begin
                ws_n = 1'b1; ww_n = head.weight;
            end
        end
        best = '0; coding = '0;
        for (int i = 0; i < 4; i++) begin
            q = seen_n[i] ? w_n[i] : (ws_n ? ww_n : 10'd0);
            if (q > best) begin
                best = q; coding = 2'(i);
            end
        end
        idw = seen_n[aen_pkg::IDENT_IDX] ? w_n[aen_pkg::IDENT_IDX] :
              (ws_n ? ww_n : aen_pkg::FULL_WEIGHT);
        if (head.malformed)     status = aen_pkg::ST_MALFORM;
        else if (!head.nonblank) status = aen_pkg::ST_PLAIN;
        else if (best != '0)    status = aen_pkg::ST_CODING;
        else if (idw != '0)     status = aen_pkg::ST_PLAIN;
        else                    status = aen_pkg::ST_NOACCEPT;
        if (status != aen_pkg::ST_CODING) begin
            best = '0; coding = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            for (int i = 0; i < 5; i++) w_reg[i] <= head.last ? 10'd0 : w_n[i];
            ww_reg <= head.last ? 10'd0 : ww_n;
        end
        if (pop && head.last) md_reg <= {2'b00, best, coding, status};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seen_reg <= '0; ws_reg <= 1'b0; mv_reg <= 1'b0;
        end else begin
            if (pop) begin
                seen_reg <= head.last ? 5'd0 : seen_n;
                ws_reg <= head.last ? 1'b0 : ws_n;
            end
            if (pop && head.last) mv_reg <= 1'b1;
            else if (m_ready)     mv_reg <= 1'b0;
        end
    end

endmodule

>>> tb/sv/testbench.sv
// Self-checking testbench for the Accept-Encoding negotiator.
// Depends on aen_pkg and accept_encoding_negotiator; predicts each decision
// from its own byte-level parser model and checks every result transfer.
`timescale 1ns / 100ps

module testbench;
    import aen_pkg::*;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = 8'd0;
    logic        s_tuser = 1'b0;
    logic        s_tlast = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;

    accept_encoding_negotiator u_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .s_tuser(s_tuser), .s_tlast(s_tlast),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    always #5 aclk = ~aclk;

    // packed from the top down, so status lands in the lowest bits
    typedef struct packed {
        logic [9:0] weight;
        logic [1:0] coding;
        status_t    status;
    } decision_t;

    decision_t   expected_decisions[$];
    int          mismatches = 0;
    int          cycles = 0;
    bit          sink_hold = 1'b0;   // long receiver hold-off
    bit          no_idle = 1'b0;     // stretch without random gaps
    localparam int CYCLE_LIMIT = 400000;

    // predictor state
    logic [4:0]  p_seen;
    logic [9:0]  p_weight [5];
    logic        p_wild_seen;
    logic [9:0]  p_wild_weight;
    phase_t      p_phase;
    logic [5:0]  p_flags;
    logic [3:0]  p_pos;
    logic        p_space;
    qstate_t     p_qs;
    logic [9:0]  p_elem_weight;
    logic        p_elem_nb;
    logic        p_field_nb;
    logic        p_bad;

    function automatic int tok_len(int i);
        case (i)
            0, 1: return 4;
            2, 3: return 3;
            4: return 8;
            default: return 1;
        endcase
    endfunction

    function automatic logic [7:0] tok_char(int i, int p);
        string s;
        case (i)
            0: s = "zstd";
            1: s = "gzip";
            2: s = "zx\x63";
            3: s = "lz4";
            4: s = "identity";
            default: s = "*";
        endcase
        return (p < s.len()) ? s[p] : 8'h00;
    endfunction

    function automatic bit is_space(logic [7:0] c);
        return c == 8'h20 || (c >= 8'h09 && c <= 8'h0d);
    endfunction

    task automatic clear_element();
        p_phase = PH_TOK_LEAD;
        p_flags = '1;
        p_pos = 0;
        p_space = 0;
        p_qs = QS_IDLE;
        p_elem_weight = FULL_WEIGHT;
        p_elem_nb = 0;
    endtask

    task automatic clear_header();
        p_seen = 0;
        for (int i = 0; i < 5; i++) p_weight[i] = 0;
        p_wild_seen = 0;
        p_wild_weight = 0;
        p_field_nb = 0;
        p_bad = 0;
        clear_element();
    endtask

    task automatic token_byte(logic [7:0] c);
        logic [7:0] lc;
        lc = (c >= "A" && c <= "Z") ? c + 8'd32 : c;
        if (p_space) p_flags = 0;
        for (int i = 0; i < 6; i++)
            if (p_pos >= tok_len(i) || tok_char(i, p_pos) != lc) p_flags[i] = 1'b0;
        if (p_pos != 4'd15) p_pos++;
    endtask

    task automatic weight_byte(logic [7:0] c);
        bit dig;
        logic [9:0] d;
        dig = c >= "0" && c <= "9";
        d = dig ? 10'(c - "0") : 10'd0;
        if (p_space) begin
            p_qs = QS_BAD;
            return;
        end
        case (p_qs)
            QS_IDLE: begin
                if (c == "0") begin p_qs = QS_ZERO; p_elem_weight = 0; end
                else if (c == "1") begin p_qs = QS_ONE; p_elem_weight = FULL_WEIGHT; end
                else p_qs = QS_BAD;
            end
            QS_ZERO: p_qs = (c == ".") ? QS_ZPT : QS_BAD;
            QS_ONE:  p_qs = (c == ".") ? QS_OPT : QS_BAD;
            QS_ZPT: begin
                if (dig) begin p_qs = QS_ZD1; p_elem_weight += d * 100; end
                else p_qs = QS_BAD;
            end
            QS_ZD1: begin
                if (dig) begin p_qs = QS_ZD2; p_elem_weight += d * 10; end
                else p_qs = QS_BAD;
            end
            QS_ZD2: begin
                if (dig) begin p_qs = QS_ZD3; p_elem_weight += d; end
                else p_qs = QS_BAD;
            end
            QS_OPT: p_qs = (c == "0") ? QS_OD1 : QS_BAD;
            QS_OD1: p_qs = (c == "0") ? QS_OD2 : QS_BAD;
            QS_OD2: p_qs = (c == "0") ? QS_OD3 : QS_BAD;
            default: p_qs = QS_BAD;
        endcase
    endtask

    task automatic close_part();
        if (p_phase == PH_TOK_LEAD || p_phase == PH_TOK_BODY) begin
            for (int i = 0; i < 6; i++)
                if (p_pos != tok_len(i)) p_flags[i] = 1'b0;
        end else if (p_phase == PH_PAR_VAL) begin
            if (p_qs == QS_IDLE || p_qs > QS_OD3) p_bad = 1;
        end
        p_space = 0;
    endtask

    task automatic close_element();
        if (p_elem_nb && !p_bad) begin
            for (int i = 0; i < 5; i++)
                if (p_flags[i] && !p_seen[i]) begin
                    p_seen[i] = 1'b1;
                    p_weight[i] = p_elem_weight;
                end
            if (p_flags[WILD_IDX]) begin
                p_wild_seen = 1;
                p_wild_weight = p_elem_weight;
            end
        end
        clear_element();
    endtask

    task automatic parse_byte(logic [7:0] c);
        bit ws;
        ws = is_space(c);
        if (!ws) p_field_nb = 1;
        if (c == ",") begin
            close_part();
            close_element();
            return;
        end
        if (!ws) p_elem_nb = 1;
        if (c == ";") begin
            close_part();
            p_phase = PH_PAR_LEAD;
            return;
        end
        case (p_phase)
            PH_TOK_LEAD: if (!ws) begin p_phase = PH_TOK_BODY; token_byte(c); end
            PH_TOK_BODY: if (ws) p_space = 1; else token_byte(c);
            PH_PAR_LEAD: if (!ws) p_phase = (c == "q" || c == "Q") ? PH_PAR_Q : PH_PAR_SKIP;
            PH_PAR_Q: begin
                if (c == "=") begin
                    p_phase = PH_PAR_VAL;
                    p_qs = QS_IDLE;
                    p_elem_weight = 0;
                    p_space = 0;
                end else p_phase = PH_PAR_SKIP;
            end
            PH_PAR_VAL: if (ws) p_space = 1; else weight_byte(c);
            default: ;
        endcase
    endtask

    function automatic logic [9:0] coding_weight(int i, logic [9:0] fallback);
        if (p_seen[i]) return p_weight[i];
        return p_wild_seen ? p_wild_weight : fallback;
    endfunction

    task automatic negotiate(output decision_t r);
        logic [9:0] best, q;
        logic [1:0] pick;
        best = 0;
        pick = 0;
        close_part();
        close_element();
        if (p_bad) r.status = ST_MALFORM;
        else if (!p_field_nb) r.status = ST_PLAIN;
        else begin
            for (int i = 0; i < 4; i++) begin
                q = coding_weight(i, 10'd0);
                if (q > best) begin best = q; pick = 2'(i); end
            end
            if (best > 0) r.status = ST_CODING;
            else r.status = (coding_weight(IDENT_IDX, FULL_WEIGHT) > 0) ? ST_PLAIN
                                                                        : ST_NOACCEPT;
        end
        r.coding = (r.status == ST_CODING) ? pick : 2'd0;
        r.weight = (r.status == ST_CODING) ? best : 10'd0;
        clear_header();
    endtask

    // one input transfer; prediction happens when the transfer is taken.
    // tvalid stays up after the transfer so items can follow with no gap;
    // an idle cycle or drain() drops it.
    task automatic send_item(logic [7:0] b, logic has, logic lst);
        decision_t r;
        while (!no_idle && $urandom_range(99) < 21) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= b;
        s_tuser <= has;
        s_tlast <= lst;
        do @(posedge aclk); while (!s_tready);
        if (has) parse_byte(b);
        if (lst) begin
            negotiate(r);
            expected_decisions.insert(expected_decisions.size(), r);
        end
        @(negedge aclk);
    endtask

    task automatic send_header(string h);
        if (h.len() == 0) send_item(8'd0, 1'b0, 1'b1);
        for (int i = 0; i < h.len(); i++) send_item(h[i], 1'b1, i == h.len() - 1);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (expected_decisions.size() != 0) @(negedge aclk);
        repeat (4) @(negedge aclk);
    endtask

    // result checker
    always @(posedge aclk) begin
        decision_t want, got;
        if (aresetn && m_tvalid && m_tready) begin
            got = decision_t'(m_tdata[13:0]);
            if (expected_decisions.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result %h", m_tdata);
            end else begin
                want = expected_decisions.pop_front();
                if (got !== want || m_tdata[15:14] !== 2'b00) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected st=%0d cod=%0d w=%0d, got st=%0d cod=%0d w=%0d",
                                 want.status, want.coding, want.weight,
                                 got.status, got.coding, got.weight);
                end
            end
        end
    end

    // receiver stalls
    always @(negedge aclk) begin
        if (sink_hold) m_tready <= 1'b0;
        else m_tready <= no_idle || ($urandom_range(99) >= 21);
    end

    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    task automatic test_directed();
        string cases[$];
        cases = '{"", "   ", "gzip", "ZSTD;q=0.5, gzip", "gzip;q=0.8, zstd;q=0.8",
                  "zx\x63;q=1.000, lz4;q=0.999", "lz4;Q=0.001", "*;q=0.3",
                  "gzip;q=0, *", "identity;q=0", "*;q=0", "identity;q=0, gzip;q=0",
                  "gzip;q=1.5", "gzip;q=", "gzip;q=0. 5", "gzip;q=0.1234",
                  "gzip;q=0.5;q=0.2", "gzip;q=0.4, gzip;q=0.9", "*;q=0.2,*;q=0.7",
                  "gzip;level=9", " ,\t, zstd ,", "gz ip", "foo;q=bad, gzip",
                  "\xff\x00gzip", "gzip;q=1."};
        foreach (cases[i]) send_header(cases[i]);
        send_item(8'h41, 1'b0, 1'b0);   // empty item, no result
        send_item(8'h7a, 1'b1, 1'b0);
        send_item(8'h00, 1'b0, 1'b1);
        drain();
    endtask

    function automatic string rand_weight();
        string s;
        int n;
        case ($urandom_range(9))
            0: return "1";
            1: return "1.000";
            2: return "0";
            3: return $sformatf("1.%0d", $urandom_range(999));
            4: return "";
            5: begin
                s = "";
                n = $urandom_range(4);
                repeat (n) s = {s, string'(8'($urandom_range(32, 126)))};
                return s;
            end
            default: begin
                s = "0.";
                n = $urandom_range(3);
                repeat (n) s = {s, string'(8'("0" + $urandom_range(9)))};
                return s;
            end
        endcase
    endfunction

    function automatic string rand_token();
        string names[$];
        string t;
        names = '{"zstd", "gzip", "zx\x63", "lz4", "identity", "*", "GZip", "ZSTD",
                  "br", "", "lz", "zstdx", "gz ip"};
        t = names[$urandom_range(names.size() - 1)];
        return t;
    endfunction

    function automatic string rand_pad();
        string ws;
        ws = " \t\n\x0b\x0c\r";
        return ($urandom_range(3) == 0) ? string'(ws[$urandom_range(5)]) : "";
    endfunction

    function automatic string rand_header();
        string h;
        int n;
        if ($urandom_range(9) == 0) begin
            h = "";
            n = $urandom_range(8);
            repeat (n) h = {h, string'(8'($urandom_range(1, 255)))};
            return h;
        end
        h = "";
        n = $urandom_range(1, 4);
        for (int e = 0; e < n; e++) begin
            if (e) h = {h, ","};
            h = {h, rand_pad(), rand_token(), rand_pad()};
            if ($urandom_range(2) != 0)
                h = {h, ";", rand_pad(), ($urandom_range(1) ? "q" : "Q"), "=",
                     rand_weight(), rand_pad()};
            if ($urandom_range(7) == 0) h = {h, ";level=", rand_pad(), "3"};
        end
        return h;
    endfunction

    // every byte value, with occasional has_byte-low items and empty end markers
    task automatic test_random(int n_items);
        int sent;
        sent = 0;
        while (sent < n_items) begin
            string h;
            h = rand_header();
            if ($urandom_range(15) == 0) begin
                send_item(8'($urandom), 1'b0, 1'b0);
                send_item(8'($urandom), 1'b1, 1'b0);
                send_item(8'($urandom), 1'b0, 1'b1);
                sent += 3;
            end else begin
                send_header(h);
                sent += (h.len() == 0) ? 1 : h.len();
            end
        end
        drain();
    endtask

    task automatic test_backpressure();
        fork
            begin
                sink_hold = 1'b1;
                repeat (300) @(negedge aclk);
                sink_hold = 1'b0;
            end
            repeat (30) send_header("gzip");
        join
        drain();
    endtask

    task automatic test_no_idle();
        no_idle = 1'b1;
        test_random(300);
        no_idle = 1'b0;
    endtask

    initial begin
        clear_header();
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);
        test_directed();
        test_backpressure();
        test_random(400);
        test_no_idle();
        test_random(400);
        if (mismatches == 0 && expected_decisions.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
